>>> hw/rtl/message_mac_signer_top_macros.svh
// Assertion helpers for the checker file.
`ifndef MESSAGE_MAC_SIGNER_TOP_MACROS_SVH
`define MESSAGE_MAC_SIGNER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/mms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mms_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_FEED,
		ST_MSG,
		ST_MSG_DONE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// Where to go once a block compression finishes.
	typedef enum logic [1:0] {
		CT_KEY,
		CT_MSG,
		CT_PAD
	} cont_t;

	// Padding phases: marker byte, zero fill, length field.
	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} pad_ph_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_SHORT    = 2'd2;

	localparam int unsigned SIG_OFFSET = 14;
	localparam int unsigned SIG_SIZE   = 8;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	// Round constant table.
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	// Rotate amount for a round.
	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	// Message word index used by a round.
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] lo;
		logic [3:0] g;
		lo = i[3:0];
		case (i[5:4])
			2'd0:    g = lo;
			2'd1:    g = lo * 4'd5 + 4'd1;
			2'd2:    g = lo * 4'd3 + 4'd5;
			default: g = lo * 4'd7;
		endcase
		return g;
	endfunction

	// Nonlinear round function.
	function automatic logic [31:0] md5_f(input logic [5:0] i, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (i[5:4])
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/message_mac_signer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Keyed MD5 message signer. Key beats (tuser mode 0) append to a key store of KEY_BYTES
// bytes, first restarting it; extra key bytes are dropped. A message beat (mode 1) that
// opens a message replays the stored key into the hash (read, then place, per key byte),
// then each message byte is accepted, placed and closed in turn; bytes 14 to 21
// are hashed as the little-endian sequence number and four zeros. Each filled 64-byte
// block goes through the single round unit, which reads one message word per cycle from
// the block RAM, then the chaining add. On tlast a message of 22 bytes or more is padded
// and one result beat gives the first eight digest bytes and a status; a shorter one gives
// a zero signature with the short status. The input accepts a new beat only between
// items; a finished result may wait at the output while the next item is taken.
module message_mac_signer_top
	import mms_pkg::*;
#(
	parameter int KEY_BYTES    = 64,
	parameter int MSG_LEN_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // data_byte[7:0], first[8], seq_num[40:9], verify[41]
	input  wire logic [0:0]  s_tuser,  // mode[0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata   // signature[63:0], status[65:64]
);

	localparam int KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KLW = $clog2(KEY_BYTES + 1);
	localparam logic [KLW-1:0] KEY_MAX = KLW'(KEY_BYTES);
	localparam logic [MSG_LEN_BITS-1:0] MIN_LEN = MSG_LEN_BITS'(SIG_OFFSET + SIG_SIZE);
	localparam logic [MSG_LEN_BITS-1:0] SIG_LO  = MSG_LEN_BITS'(SIG_OFFSET);

	state_t  state_q, state_d;
	cont_t   cont_q;
	pad_ph_t ph_q;

	logic [KLW-1:0]          key_len_q, key_idx_q;
	logic [31:0]             cv0_q, cv1_q, cv2_q, cv3_q;
	logic [31:0]             a_q, b_q, c_q, d_q;
	logic [5:0]              rnd_q;
	logic [63:0]             hlen_q, len_bits_q;
	logic [23:0]             word_q;
	logic [MSG_LEN_BITS-1:0] bc_q;
	logic [63:0]             rsig_q;
	logic [31:0]             seq_q;
	logic                    verify_q, open_q, last_q, fin_q;
	logic [7:0]              data_q;
	logic [65:0]             res_q;
	logic                    m_tvalid_q;
	logic [65:0]             m_tdata_q;

	// Input beat fields.
	logic       in_acc, in_mode, in_first;
	assign in_acc   = s_tvalid && s_tready;
	assign in_mode  = s_tuser[0];
	assign in_first = s_tdata[8];

	// Memories.
	logic            key_we;
	logic [KAW-1:0]  key_waddr;
	logic [7:0]      key_rdata;
	logic            blk_we;
	logic [3:0]      blk_raddr;
	logic [31:0]     blk_rdata;

	// Byte placement into the current block.
	logic        place_en;
	logic [7:0]  place_byte;
	logic        blk_full;
	logic        in_sig;
	logic [2:0]  sig_k;
	logic [7:0]  msg_hv;
	logic        len_byte;

	// Round and chaining arithmetic.
	logic [31:0] rnd_sum, rnd_rot, sum0, sum1;
	logic [4:0]  rnd_s;
	logic [63:0] dig;
	logic        open_new;

	assign key_waddr = in_first ? '0 : key_len_q[KAW-1:0];

	mms_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (s_tdata[7:0]),
		.raddr (key_idx_q[KAW-1:0]),
		.rdata (key_rdata)
	);

	mms_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (hlen_q[5:2]),
		.wdata ({place_byte, word_q}),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	// Message byte substitution in the signature field.
	assign in_sig   = (bc_q >= SIG_LO) && (bc_q < MIN_LEN);
	assign sig_k    = 3'(bc_q - SIG_LO);
	assign msg_hv   = in_sig ? (sig_k[2] ? 8'h00 : seq_q[8*sig_k[1:0] +: 8]) : data_q;
	assign len_byte = (ph_q == PH_LEN) || (ph_q == PH_ZERO && hlen_q[5:0] == 6'd56);

	// One MD5 round.
	assign rnd_s   = md5_s(rnd_q);
	assign rnd_sum = a_q + md5_f(rnd_q, b_q, c_q, d_q) + md5_k(rnd_q) + blk_rdata;
	assign rnd_rot = (rnd_sum << rnd_s) | (rnd_sum >> (6'd32 - {1'b0, rnd_s}));
	assign sum0    = cv0_q + a_q;
	assign sum1    = cv1_q + b_q;
	assign dig     = {sum1, sum0};
	assign open_new = in_first || !open_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_mode) begin
					if (open_new && key_len_q != '0) state_d = ST_KEY_RD;
					else state_d = ST_MSG;
				end
			end
			ST_KEY_RD: state_d = ST_KEY_FEED;
			ST_KEY_FEED: begin
				if (blk_full) state_d = ST_ROUND;
				else if (key_idx_q + KLW'(1) < key_len_q) state_d = ST_KEY_RD;
				else state_d = ST_MSG;
			end
			ST_MSG: state_d = blk_full ? ST_ROUND : ST_MSG_DONE;
			ST_MSG_DONE: begin
				if (!last_q) state_d = ST_IDLE;
				else if (bc_q < MIN_LEN) state_d = ST_OUT;
				else state_d = ST_PAD;
			end
			ST_PAD: state_d = blk_full ? ST_ROUND : ST_PAD;
			ST_ROUND: state_d = (rnd_q == 6'd63) ? ST_ADD : ST_ROUND;
			ST_ADD: begin
				unique case (cont_q)
					CT_KEY:  state_d = (key_idx_q < key_len_q) ? ST_KEY_RD : ST_MSG;
					CT_MSG:  state_d = ST_MSG_DONE;
					default: state_d = fin_q ? ST_OUT : ST_PAD;
				endcase
			end
			ST_OUT: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		key_we     = in_acc && !in_mode && (in_first || key_len_q < KEY_MAX);
		place_en   = 1'b0;
		place_byte = 8'h00;
		blk_raddr  = (state_q == ST_ROUND) ? md5_g(rnd_q + 6'd1) : 4'd0;
		unique case (state_q)
			ST_KEY_FEED: begin
				place_en   = 1'b1;
				place_byte = key_rdata;
			end
			ST_MSG: begin
				place_en   = 1'b1;
				place_byte = msg_hv;
			end
			ST_PAD: begin
				place_en = 1'b1;
				if (ph_q == PH_MARK) place_byte = 8'h80;
				else if (len_byte) place_byte = len_bits_q[8*hlen_q[2:0] +: 8];
				else place_byte = 8'h00;
			end
			default: place_en = 1'b0;
		endcase
		blk_we   = place_en && (hlen_q[1:0] == 2'd3);
		blk_full = place_en && (hlen_q[5:0] == 6'd63);
	end

	// Registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cont_q     <= CT_KEY;
			ph_q       <= PH_MARK;
			key_len_q  <= '0;
			key_idx_q  <= '0;
			cv0_q      <= IV0;
			cv1_q      <= IV1;
			cv2_q      <= IV2;
			cv3_q      <= IV3;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			d_q        <= '0;
			rnd_q      <= '0;
			hlen_q     <= '0;
			len_bits_q <= '0;
			word_q     <= '0;
			bc_q       <= '0;
			rsig_q     <= '0;
			seq_q      <= '0;
			verify_q   <= 1'b0;
			open_q     <= 1'b0;
			last_q     <= 1'b0;
			fin_q      <= 1'b0;
			data_q     <= '0;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			state_q <= state_d;

			// Key load and message open.
			if (in_acc && !in_mode) begin
				if (in_first) key_len_q <= KLW'(1);
				else if (key_len_q < KEY_MAX) key_len_q <= key_len_q + KLW'(1);
			end
			if (in_acc && in_mode) begin
				data_q <= s_tdata[7:0];
				last_q <= s_tlast;
				if (open_new) begin
					cv0_q     <= IV0;
					cv1_q     <= IV1;
					cv2_q     <= IV2;
					cv3_q     <= IV3;
					hlen_q    <= '0;
					bc_q      <= '0;
					rsig_q    <= '0;
					seq_q     <= s_tdata[40:9];
					verify_q  <= s_tdata[41];
					open_q    <= 1'b1;
					key_idx_q <= '0;
				end
			end

			// Byte placement and block hand-off; the fourth byte of a word goes
			// straight to the block RAM.
			if (place_en) begin
				case (hlen_q[1:0])
					2'd0:    word_q[7:0]   <= place_byte;
					2'd1:    word_q[15:8]  <= place_byte;
					2'd2:    word_q[23:16] <= place_byte;
					default: word_q        <= word_q;
				endcase
				hlen_q <= hlen_q + 64'd1;
			end
			if (blk_full) begin
				a_q   <= cv0_q;
				b_q   <= cv1_q;
				c_q   <= cv2_q;
				d_q   <= cv3_q;
				rnd_q <= '0;
			end
			if (state_q == ST_KEY_FEED) begin
				key_idx_q <= key_idx_q + KLW'(1);
				cont_q    <= CT_KEY;
			end
			if (state_q == ST_MSG) begin
				cont_q <= CT_MSG;
				if (in_sig) rsig_q[8*sig_k +: 8] <= data_q;
				if (bc_q != '1) bc_q <= bc_q + MSG_LEN_BITS'(1);
			end

			// End of message: short result or start of padding.
			if (state_q == ST_MSG_DONE && last_q) begin
				open_q     <= 1'b0;
				res_q      <= {STATUS_SHORT, 64'd0};
				len_bits_q <= {hlen_q[60:0], 3'b000};
				ph_q       <= PH_MARK;
				fin_q      <= 1'b0;
			end
			if (state_q == ST_PAD) begin
				cont_q <= CT_PAD;
				if (ph_q == PH_MARK) ph_q <= PH_ZERO;
				else if (len_byte) ph_q <= PH_LEN;
				if (len_byte && ph_q != PH_MARK && hlen_q[5:0] == 6'd63) fin_q <= 1'b1;
			end

			// Rounds and chaining add.
			if (state_q == ST_ROUND) begin
				a_q   <= d_q;
				b_q   <= b_q + rnd_rot;
				c_q   <= b_q;
				d_q   <= c_q;
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_ADD) begin
				cv0_q <= sum0;
				cv1_q <= sum1;
				cv2_q <= cv2_q + c_q;
				cv3_q <= cv3_q + d_q;
				res_q <= {(verify_q && dig != rsig_q) ? STATUS_MISMATCH : STATUS_OK, dig};
			end

			// Output register.
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= res_q;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_tdata_q};

endmodule
`default_nettype wire

>>> hw/rtl/mms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "message_mac_signer_top_macros.svh"
module mms_checker
	import mms_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);

	// A stalled result beat stays offered and unchanged.
	`MMS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`MMS_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

	// Status is one of the defined codes, and a short message carries no signature.
	`MMS_ASSERT_IMP(a_status_code, m_tvalid,
		m_tdata[65:64] == STATUS_OK || m_tdata[65:64] == STATUS_MISMATCH ||
		m_tdata[65:64] == STATUS_SHORT)
	`MMS_ASSERT_IMP(a_short_zero, m_tvalid && m_tdata[65:64] == STATUS_SHORT,
		m_tdata[63:0] == 64'd0)

endmodule

bind message_mac_signer_top mms_checker u_mms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

>>> sim/mms_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the signer, predicts every signature beat and compares.
module mms_scoreboard
	import mms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,  // data_byte[7:0], first[8], seq_num[40:9], verify[41]
	input  wire logic [0:0]  s_tuser,  // mode[0]
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,  // signature[63:0], status[65:64]
	output int               errors,
	output int               pending,
	output int               sigs_seen,
	output logic [63:0]      last_sig
);

	localparam int unsigned KEY_MAX   = 64;
	localparam int unsigned COUNT_TOP = (1 << 24) - 1;

	localparam bit [31:0] RCONST [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int unsigned ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};

	typedef struct packed {
		logic [63:0] sig;
		logic [1:0]  status;
	} sig_beat_t;

	sig_beat_t   sig_q[$];
	bit [7:0]    key_mem[KEY_MAX];
	int unsigned key_len;
	bit [31:0]   chain[4];
	bit [7:0]    blk[64];
	int unsigned msg_count;
	bit [63:0]   rx_sig;
	bit [31:0]   seq_held;
	bit          verify_held;
	bit          in_msg;
	bit [63:0]   hash_len;

	// One 64-round compression of the block into the chaining value.
	function automatic void compress_block();
		bit [31:0] w[16];
		bit [31:0] a, b, c, d, f, t, x;
		int unsigned g, s;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3 * i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * i) % 16;
			end
			s = ROT[(i / 16) * 4 + (i % 4)];
			x = a + f + RCONST[i] + w[g];
			t = d; d = c; c = b;
			b = b + ((x << s) | (x >> (32 - s)));
			a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endfunction

	function automatic void put_byte(bit [63:0] pos, bit [7:0] v);
		blk[pos[5:0]] = v;
		if (pos[5:0] == 6'd63)
			compress_block();
	endfunction

	function automatic void hash_byte(bit [7:0] v);
		put_byte(hash_len, v);
		hash_len++;
	endfunction

	// Pads the stream and returns the first eight digest bytes.
	function automatic bit [63:0] finish_digest();
		bit [63:0] pos, bits, sig;
		pos = hash_len;
		bits = hash_len << 3;
		put_byte(pos, 8'h80);
		pos++;
		while (pos[5:0] != 6'd56) begin
			put_byte(pos, 8'h00);
			pos++;
		end
		for (int i = 0; i < 8; i++) begin
			put_byte(pos, bits[8*i +: 8]);
			pos++;
		end
		for (int i = 0; i < 8; i++)
			sig[8*i +: 8] = chain[i / 4][8*(i % 4) +: 8];
		return sig;
	endfunction

	// Advances the signer state by one input beat; returns 1 when a signature is due.
	function automatic bit sign_beat(bit mode, bit [7:0] d, bit f, bit l, bit [31:0] sq,
			bit v, output sig_beat_t res);
		int unsigned k;
		bit [7:0] hv;
		res = '0;
		if (!mode) begin
			if (f)
				key_len = 0;
			if (key_len < KEY_MAX) begin
				key_mem[key_len] = d;
				key_len++;
			end
			return 0;
		end
		if (f || !in_msg) begin
			chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
			chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
			hash_len = 0;
			for (int i = 0; i < key_len; i++)
				hash_byte(key_mem[i]);
			msg_count = 0;
			rx_sig = 0;
			seq_held = sq;
			verify_held = v;
			in_msg = 1;
		end
		hv = d;
		if (msg_count >= SIG_OFFSET && msg_count < SIG_OFFSET + SIG_SIZE) begin
			k = msg_count - SIG_OFFSET;
			rx_sig[8*k +: 8] = d;
			hv = (k < 4) ? seq_held[8*k +: 8] : 8'h00;
		end
		hash_byte(hv);
		if (msg_count < COUNT_TOP)
			msg_count++;
		if (!l)
			return 0;
		in_msg = 0;
		if (msg_count < SIG_OFFSET + SIG_SIZE) begin
			res.sig = '0;
			res.status = STATUS_SHORT;
		end else begin
			res.sig = finish_digest();
			res.status = (verify_held && res.sig != rx_sig) ? STATUS_MISMATCH : STATUS_OK;
		end
		return 1;
	endfunction

	// Predict on every input beat and compare on every output beat.
	always @(posedge clk or negedge arst_n) begin
		sig_beat_t exp_beat;
		sig_beat_t got;
		if (!arst_n) begin
			sig_q.delete();
			key_len = 0; msg_count = 0; rx_sig = 0; seq_held = 0;
			verify_held = 0; in_msg = 0; hash_len = 0;
			errors = 0; pending = 0; sigs_seen = 0; last_sig = '0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (sign_beat(s_tuser[0], s_tdata[7:0], s_tdata[8], s_tlast, s_tdata[40:9],
						s_tdata[41], exp_beat)) begin
					sig_q.push_back(exp_beat);
					last_sig = exp_beat.sig;
				end
			end
			if (m_tvalid && m_tready) begin
				got.sig = m_tdata[63:0];
				got.status = m_tdata[65:64];
				sigs_seen++;
				if (sig_q.size() == 0) begin
					$display("%0t: unexpected signature beat %h", $time, m_tdata);
					errors++;
				end else begin
					exp_beat = sig_q.pop_front();
					if (got.sig !== exp_beat.sig || got.status !== exp_beat.status ||
							m_tdata[71:66] !== 6'd0) begin
						$display("%0t: expected sig %h status %0d, got sig %h status %0d (%h)",
							$time, exp_beat.sig, exp_beat.status, got.sig, got.status,
							m_tdata);
						errors++;
					end
				end
			end
			pending = sig_q.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Drives key loads and messages into the signer and gives the verdict.
module tb;
	import mms_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // data_byte[7:0], first[8], seq_num[40:9], verify[41]
	logic [0:0]  s_tuser;  // mode[0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;  // signature[63:0], status[65:64]

	int          errors, pending, sigs_seen;
	logic [63:0] last_sig;
	int          idle_s, idle_r;
	int          beats, msgs;
	bit          hold_go;
	int          hold_cnt;
	bit          hold_done;
	int          quiet;

	message_mac_signer_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	mms_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending), .sigs_seen(sigs_seen), .last_sig(last_sig)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Receiver: random back-pressure, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_go && !hold_done) begin
				hold_cnt = 600;
				hold_done = 1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_r);
			end
		end
	end

	// Watchdog on cycles with no beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet > IDLE_LIMIT) begin
			$display("Watchdog expired at %0t", $time);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_beat(bit mode, bit [7:0] d, bit f, bit l, bit [31:0] sq, bit v);
		while ($urandom_range(99) < idle_s) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, v, sq, f, d};
		s_tuser <= mode;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats++;
	endtask

	task automatic load_key(int n);
		for (int i = 0; i < n; i++)
			send_beat(1'b0, 8'($urandom), i == 0, 1'($urandom), $urandom, 1'($urandom));
	endtask

	// One message; with good_sig the signature field carries the real digest.
	task automatic send_msg(int len, bit v, bit use_first, bit key_inside, bit good_sig,
			bit [31:0] sq, int fill);
		bit [7:0] b[];
		b = new[len];
		for (int i = 0; i < len; i++)
			b[i] = (fill >= 0) ? 8'(fill) : 8'($urandom);
		if (good_sig) begin
			for (int i = 0; i < len; i++)
				send_beat(1'b1, b[i], i == 0, i == len - 1, sq, 1'b0);
			s_tvalid <= 1'b0;
			@(posedge clk);
			@(posedge clk);
			for (int i = 0; i < 8; i++)
				if (SIG_OFFSET + i < len)
					b[SIG_OFFSET + i] = last_sig[8*i +: 8];
		end
		for (int i = 0; i < len; i++) begin
			if (key_inside && i == len / 2)
				send_beat(1'b0, 8'($urandom), 1'($urandom), 1'($urandom), $urandom, 1'($urandom));
			send_beat(1'b1, b[i], use_first && i == 0, i == len - 1,
				(i == 0) ? sq : $urandom, (i == 0) ? v : 1'($urandom));
		end
		msgs++;
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		idle_s = 9;
		idle_r = 61;
		beats = 0; msgs = 0; quiet = 0;
		hold_go = 0; hold_cnt = 0; hold_done = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: message with no first after reset and an empty key.
		send_msg(24, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 0);
		load_key(16);
		send_msg(1, 1'b1, 1'b1, 1'b0, 1'b0, 32'hffffffff, 255);
		send_msg(21, 1'b0, 1'b1, 1'b0, 1'b0, 32'h12345678, -1);
		send_msg(22, 1'b0, 1'b1, 1'b0, 1'b0, 32'hffffffff, 255);
		send_msg(22, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 0);
		send_msg(40, 1'b1, 1'b1, 1'b0, 1'b1, 32'h89abcdef, -1);
		load_key(70);
		send_msg(130, 1'b1, 1'b1, 1'b1, 1'b1, $urandom, -1);
		send_msg(30, 1'b0, 1'b1, 1'b1, 1'b0, $urandom, -1);

		// Random traffic in three back-pressure phases.
		while (beats < 1800) begin
			if (beats > 600 && beats <= 1200) begin
				idle_s = 61; idle_r = 9;
			end else if (beats > 1200) begin
				idle_s = 0; idle_r = 0;
			end
			if (beats > 300)
				hold_go = 1;
			if ($urandom_range(9) == 0) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
				load_key($urandom_range(3) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 20));
			end
			len = ($urandom_range(19) == 0) ? $urandom_range(120, 200) :
				($urandom_range(4) == 0 ? $urandom_range(1, 21) : $urandom_range(22, 70));
			send_msg(len, 1'($urandom), $urandom_range(7) != 0, $urandom_range(9) == 0,
				$urandom_range(3) == 0, $urandom, -1);
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("Sent %0d beats in %0d messages with key reloads; checked %0d signatures.",
			beats, msgs, sigs_seen);
		$display("Covered short, generate, verify match and mismatch, key overflow cases.");
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mms_pkg.sv
hw/rtl/mms_ram.sv
hw/rtl/message_mac_signer_top.sv
hw/rtl/mms_checker.sv
sim/mms_checker.sv
sim/tb.sv
